[rtl/mke_pkg.sv]
// Shared types, constants and the Morse code table of the keying encoder.
// Used by the RTL and the verif files; depends on nothing else.
`default_nettype none

package mke_pkg;

   localparam int SymbolWidth = 8;
   localparam int UnitsWidth  = 6;
   localparam int DashWidth   = 4;
   localparam int CsrIdxWidth = 2;
   localparam int CodeMax     = 6;
   localparam int CodeLenWidth = $clog2(CodeMax + 1);

   localparam logic [DashWidth-1:0]  DashReset       = 4'd3;
   localparam logic [UnitsWidth-1:0] LetterGapReset  = 6'd2;
   localparam logic [UnitsWidth-1:0] WordGapReset    = 6'd6;
   localparam logic [UnitsWidth-1:0] MessageGapReset = 6'd31;

   localparam logic [SymbolWidth-1:0] SpaceChar = 8'h20;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_DASH        = 2'd0,
      CSR_LETTER_GAP  = 2'd1,
      CSR_WORD_GAP    = 2'd2,
      CSR_MESSAGE_GAP = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LGAP,
      ST_WGAP,
      ST_ON,
      ST_OFF,
      ST_MGAP
   } seq_state_type;

   // Elements read left to right from bit CodeMax-1; a set bit is a dash.
   typedef struct packed {
      logic [CodeLenWidth-1:0] len;
      logic [CodeMax-1:0]      pat;
   } code_type;

   // Key lengths with a zero register already taken as one unit.
   typedef struct packed {
      logic [UnitsWidth-1:0] dash;
      logic [UnitsWidth-1:0] letter_gap;
      logic [UnitsWidth-1:0] word_gap;
      logic [UnitsWidth-1:0] message_gap;
   } cfg_type;

   typedef struct packed {
      logic                  key_on;
      logic [UnitsWidth-1:0] units;
      logic                  last;
   } beat_type;

   function automatic logic [SymbolWidth-1:0] fold_case(input logic [SymbolWidth-1:0] ch);
      logic [SymbolWidth-1:0] res;
      res = ch;
      if (ch >= 8'h41 && ch <= 8'h5A) begin
         res = ch | 8'h20;
      end
      return res;
   endfunction

   function automatic logic [UnitsWidth-1:0] at_least_one(input logic [UnitsWidth-1:0] v);
      return (v == '0) ? UnitsWidth'(1) : v;
   endfunction

   function automatic code_type lookup_code(input logic [SymbolWidth-1:0] ch);
      code_type c;
      case (ch)
         8'h61:   c = '{len: 3'd2, pat: 6'b010000};  // a
         8'h62:   c = '{len: 3'd4, pat: 6'b100000};  // b
         8'h63:   c = '{len: 3'd4, pat: 6'b101000};  // c
         8'h64:   c = '{len: 3'd3, pat: 6'b100000};  // d
         8'h65:   c = '{len: 3'd1, pat: 6'b000000};  // e
         8'h66:   c = '{len: 3'd4, pat: 6'b001000};  // f
         8'h67:   c = '{len: 3'd3, pat: 6'b110000};  // g
         8'h68:   c = '{len: 3'd4, pat: 6'b000000};  // h
         8'h69:   c = '{len: 3'd2, pat: 6'b000000};  // i
         8'h6A:   c = '{len: 3'd4, pat: 6'b011100};  // j
         8'h6B:   c = '{len: 3'd3, pat: 6'b101000};  // k
         8'h6C:   c = '{len: 3'd4, pat: 6'b010000};  // l
         8'h6D:   c = '{len: 3'd2, pat: 6'b110000};  // m
         8'h6E:   c = '{len: 3'd2, pat: 6'b100000};  // n
         8'h6F:   c = '{len: 3'd3, pat: 6'b111000};  // o
         8'h70:   c = '{len: 3'd4, pat: 6'b011000};  // p
         8'h71:   c = '{len: 3'd4, pat: 6'b110100};  // q
         8'h72:   c = '{len: 3'd3, pat: 6'b010000};  // r
         8'h73:   c = '{len: 3'd3, pat: 6'b000000};  // s
         8'h74:   c = '{len: 3'd1, pat: 6'b100000};  // t
         8'h75:   c = '{len: 3'd3, pat: 6'b001000};  // u
         8'h76:   c = '{len: 3'd4, pat: 6'b000100};  // v
         8'h77:   c = '{len: 3'd3, pat: 6'b011000};  // w
         8'h78:   c = '{len: 3'd4, pat: 6'b100100};  // x
         8'h79:   c = '{len: 3'd4, pat: 6'b101100};  // y
         8'h7A:   c = '{len: 3'd4, pat: 6'b110000};  // z
         8'h2E:   c = '{len: 3'd6, pat: 6'b010101};  // full stop
         8'h2C:   c = '{len: 3'd6, pat: 6'b110011};  // comma
         8'h3F:   c = '{len: 3'd6, pat: 6'b001100};  // question mark
         8'h3B:   c = '{len: 3'd6, pat: 6'b101010};  // semicolon
         8'h3A:   c = '{len: 3'd6, pat: 6'b111000};  // colon
         8'h21:   c = '{len: 3'd6, pat: 6'b101011};  // exclamation mark
         default: c = '{len: 3'd0, pat: 6'b000000};
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

[rtl/mke_sequencer.sv]
// Keying sequencer: looks up a character and steps through its key levels,
// one beat per cycle while the output slot is free, through a shared
// element shift register and counter. Depends on mke_pkg.
`default_nettype none

module mke_sequencer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [mke_pkg::SymbolWidth-1:0]     symbol,
   input  wire logic                                message_end,
   input  wire mke_pkg::cfg_type                    cfg,
   input  wire logic                                slot_free,
   output logic                                     idle,
   output logic                                     beat_valid,
   output mke_pkg::beat_type                        beat
);

   mke_pkg::seq_state_type state_ff, state_in;
   logic [mke_pkg::CodeMax-1:0]      pat_ff;
   logic [mke_pkg::CodeLenWidth-1:0] left_ff;
   logic                             space_ff;
   logic                             end_ff;
   logic                             prev_ff;

   logic [mke_pkg::SymbolWidth-1:0] folded;
   mke_pkg::code_type               code;
   logic                            space_now;
   mke_pkg::seq_state_type          first_body;
   mke_pkg::seq_state_type          tail_state;
   mke_pkg::seq_state_type          body_state;
   mke_pkg::seq_state_type          after_state;
   logic                            advance;

   assign folded    = mke_pkg::fold_case(symbol);
   assign code      = mke_pkg::lookup_code(folded);
   assign space_now = (folded == mke_pkg::SpaceChar);
   assign idle      = (state_ff == mke_pkg::ST_IDLE);
   assign advance   = beat_valid && slot_free;

   always_comb begin
      // first state for the item being taken now when it needs no letter gap
      if (space_now) begin
         first_body = mke_pkg::ST_WGAP;
      end else if (code.len != '0) begin
         first_body = mke_pkg::ST_ON;
      end else if (message_end) begin
         first_body = mke_pkg::ST_MGAP;
      end else begin
         first_body = mke_pkg::ST_IDLE;
      end

      tail_state = end_ff ? mke_pkg::ST_MGAP : mke_pkg::ST_IDLE;
      if (space_ff) begin
         body_state = mke_pkg::ST_WGAP;
      end else if (left_ff != '0) begin
         body_state = mke_pkg::ST_ON;
      end else begin
         body_state = tail_state;
      end

      state_in    = state_ff;
      after_state = mke_pkg::ST_IDLE;
      beat_valid  = 1'b0;
      beat        = '{key_on: 1'b0, units: mke_pkg::UnitsWidth'(1), last: 1'b0};

      case (state_ff)
         mke_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (!space_now && prev_ff) ? mke_pkg::ST_LGAP : first_body;
            end
         end
         mke_pkg::ST_LGAP: begin
            beat_valid  = 1'b1;
            beat.units  = cfg.letter_gap;
            after_state = body_state;
         end
         mke_pkg::ST_WGAP: begin
            beat_valid  = 1'b1;
            beat.units  = cfg.word_gap;
            after_state = tail_state;
         end
         mke_pkg::ST_ON: begin
            beat_valid  = 1'b1;
            beat.key_on = 1'b1;
            beat.units  = pat_ff[mke_pkg::CodeMax-1] ? cfg.dash : mke_pkg::UnitsWidth'(1);
            after_state = mke_pkg::ST_OFF;
         end
         mke_pkg::ST_OFF: begin
            beat_valid  = 1'b1;
            after_state = (left_ff != mke_pkg::CodeLenWidth'(1)) ? mke_pkg::ST_ON : tail_state;
         end
         mke_pkg::ST_MGAP: begin
            beat_valid  = 1'b1;
            beat.units  = cfg.message_gap;
            after_state = mke_pkg::ST_IDLE;
         end
         default: begin
            state_in = mke_pkg::ST_IDLE;
         end
      endcase

      if (beat_valid) begin
         beat.last = (after_state == mke_pkg::ST_IDLE);
         if (slot_free) begin
            state_in = after_state;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mke_pkg::ST_IDLE;
         prev_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (start && idle) begin
            prev_ff <= !space_now && !message_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && idle) begin
         pat_ff   <= code.pat;
         left_ff  <= code.len;
         space_ff <= space_now;
         end_ff   <= message_end;
      end else if (advance && state_ff == mke_pkg::ST_OFF) begin
         // drop the element just sent
         pat_ff  <= pat_ff << 1;
         left_ff <= left_ff - mke_pkg::CodeLenWidth'(1);
      end
   end

   a_on_has_element: assert property (@(posedge clock) disable iff (reset)
      state_ff == mke_pkg::ST_ON |-> left_ff != '0)
      else $error("key-on state with no element left");

   a_on_then_off: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mke_pkg::ST_ON && slot_free) |=> state_ff == mke_pkg::ST_OFF)
      else $error("key-on not followed by key-off");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (advance && beat.last) |=> state_ff == mke_pkg::ST_IDLE)
      else $error("sequencer busy after final beat");

   a_end_clears_prev: assert property (@(posedge clock) disable iff (reset)
      (start && idle && message_end) |=> !prev_ff)
      else $error("message end left a pending letter gap");

endmodule

`default_nettype wire

[rtl/morse_keying_encoder.sv]
// Top level of the Morse keying encoder: control registers, output register
// and the keying sequencer. Depends on mke_pkg and mke_sequencer.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_symbol, req_message_end
//   rsp      out        rsp_valid/stall    rsp_key_on, rsp_units, rsp_last
//   csr      in         csr_write          csr_index, csr_data
//
// An item is taken while the sequencer is idle, then gives one beat per
// cycle unless rsp stalls; an item with no result gives no beat.
// The sequencer steps one key level per cycle through the element register.
// Reset is synchronous; it restores the register defaults and forgets the
// previous character. A stalled rsp beat holds the sequencer in place.
`default_nettype none

module morse_keying_encoder (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [mke_pkg::SymbolWidth-1:0]      req_symbol,
   input  wire logic                                 req_message_end,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_key_on,
   output logic [mke_pkg::UnitsWidth-1:0]            rsp_units,
   output logic                                      rsp_last,
   input  wire logic                                 csr_write,
   input  wire logic [mke_pkg::CsrIdxWidth-1:0]      csr_index,
   input  wire logic [mke_pkg::UnitsWidth-1:0]       csr_data
);

   logic [mke_pkg::DashWidth-1:0]  dash_ff;
   logic [mke_pkg::UnitsWidth-1:0] letter_gap_ff;
   logic [mke_pkg::UnitsWidth-1:0] word_gap_ff;
   logic [mke_pkg::UnitsWidth-1:0] message_gap_ff;

   logic              rsp_valid_ff;
   mke_pkg::beat_type rsp_beat_ff;

   mke_pkg::cfg_type  cfg;
   mke_pkg::beat_type beat;
   logic              beat_valid;
   logic              seq_idle;
   logic              slot_free;
   logic              start;

   always_ff @(posedge clock) begin
      if (reset) begin
         dash_ff        <= mke_pkg::DashReset;
         letter_gap_ff  <= mke_pkg::LetterGapReset;
         word_gap_ff    <= mke_pkg::WordGapReset;
         message_gap_ff <= mke_pkg::MessageGapReset;
      end else if (csr_write) begin
         case (csr_index)
            mke_pkg::CSR_DASH:        dash_ff        <= csr_data[mke_pkg::DashWidth-1:0];
            mke_pkg::CSR_LETTER_GAP:  letter_gap_ff  <= csr_data;
            mke_pkg::CSR_WORD_GAP:    word_gap_ff    <= csr_data;
            mke_pkg::CSR_MESSAGE_GAP: message_gap_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign cfg.dash        = mke_pkg::at_least_one(mke_pkg::UnitsWidth'(dash_ff));
   assign cfg.letter_gap  = mke_pkg::at_least_one(letter_gap_ff);
   assign cfg.word_gap    = mke_pkg::at_least_one(word_gap_ff);
   assign cfg.message_gap = mke_pkg::at_least_one(message_gap_ff);

   assign req_stall = !seq_idle;
   assign start     = req_valid && seq_idle;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   mke_sequencer u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .symbol      (req_symbol),
      .message_end (req_message_end),
      .cfg         (cfg),
      .slot_free   (slot_free),
      .idle        (seq_idle),
      .beat_valid  (beat_valid),
      .beat        (beat)
   );

   // output register: load when empty or being taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (slot_free) begin
         rsp_valid_ff <= beat_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free && beat_valid) begin
         rsp_beat_ff <= beat;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_key_on = rsp_beat_ff.key_on;
   assign rsp_units  = rsp_beat_ff.units;
   assign rsp_last   = rsp_beat_ff.last;

endmodule

`default_nettype wire

[verif/mke_checker.sv]
// Checker for the Morse keying encoder: watches the req, rsp and csr ports,
// predicts the key levels of every accepted character and compares each rsp beat.
// Depends on mke_pkg for the beat layout, field widths and register indexes.

module mke_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   input  wire logic                               req_stall,
   input  wire logic [mke_pkg::SymbolWidth-1:0]    req_symbol,
   input  wire logic                               req_message_end,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   input  wire logic                               rsp_key_on,
   input  wire logic [mke_pkg::UnitsWidth-1:0]     rsp_units,
   input  wire logic                               rsp_last,
   input  wire logic                               csr_write,
   input  wire logic [mke_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [mke_pkg::UnitsWidth-1:0]     csr_data,
   output int                                      mismatches,
   output int                                      outstanding
);

   mke_pkg::beat_type expected_keying[$];

   logic [mke_pkg::DashWidth-1:0]  dash_len;
   logic [mke_pkg::UnitsWidth-1:0] letter_gap;
   logic [mke_pkg::UnitsWidth-1:0] word_gap;
   logic [mke_pkg::UnitsWidth-1:0] message_gap;
   logic                           after_nonspace;
   int                             beat_count;

   // A register left at zero keys for one unit.
   function automatic logic [mke_pkg::UnitsWidth-1:0] one_if_zero(
         input logic [mke_pkg::UnitsWidth-1:0] v);
      return (v == '0) ? 6'd1 : v;
   endfunction

   // Elements of a lower-case character, dots and dashes; empty if unknown.
   function automatic string morse_elements(input logic [7:0] ch);
      case (ch)
         8'h61: return ".-";     8'h62: return "-...";   8'h63: return "-.-.";
         8'h64: return "-..";    8'h65: return ".";      8'h66: return "..-.";
         8'h67: return "--.";    8'h68: return "....";   8'h69: return "..";
         8'h6A: return ".---";   8'h6B: return "-.-";    8'h6C: return ".-..";
         8'h6D: return "--";     8'h6E: return "-.";     8'h6F: return "---";
         8'h70: return ".--.";   8'h71: return "--.-";   8'h72: return ".-.";
         8'h73: return "...";    8'h74: return "-";      8'h75: return "..-";
         8'h76: return "...-";   8'h77: return ".--";    8'h78: return "-..-";
         8'h79: return "-.--";   8'h7A: return "--..";
         8'h2E: return ".-.-.-"; 8'h2C: return "--..--"; 8'h3F: return "..--..";
         8'h3B: return "-.-.-."; 8'h3A: return "---..."; 8'h21: return "-.-.--";
         default: return "";
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("mke_checker: %0t: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic predict_keying(input logic [7:0] raw, input logic fin);
      mke_pkg::beat_type levels[16];
      logic [7:0]        ch;
      logic              spacing;
      string             code;
      int                n;
      n = 0;
      ch = raw;
      if (raw >= 8'h41 && raw <= 8'h5A) begin
         ch = raw + 8'h20;
      end
      spacing = (ch == mke_pkg::SpaceChar);
      if (!spacing && after_nonspace) begin
         levels[n] = '{key_on: 1'b0, units: one_if_zero(letter_gap), last: 1'b0};
         n++;
      end
      if (spacing) begin
         levels[n] = '{key_on: 1'b0, units: one_if_zero(word_gap), last: 1'b0};
         n++;
      end else begin
         code = morse_elements(ch);
         for (int i = 0; i < code.len(); i++) begin
            levels[n] = '{key_on: 1'b1, last: 1'b0,
                          units: (code[i] == "-") ? one_if_zero({2'b00, dash_len}) : 6'd1};
            levels[n+1] = '{key_on: 1'b0, units: 6'd1, last: 1'b0};
            n += 2;
         end
      end
      after_nonspace = !spacing;
      if (fin) begin
         levels[n] = '{key_on: 1'b0, units: one_if_zero(message_gap), last: 1'b0};
         n++;
         after_nonspace = 1'b0;
      end
      if (n > 0) begin
         levels[n-1].last = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         expected_keying.push_back(levels[i]);
      end
   endtask

   always @(posedge clock) begin
      mke_pkg::beat_type want;
      if (reset) begin
         dash_len       = mke_pkg::DashReset;
         letter_gap     = mke_pkg::LetterGapReset;
         word_gap       = mke_pkg::WordGapReset;
         message_gap    = mke_pkg::MessageGapReset;
         after_nonspace = 1'b0;
         beat_count     = 0;
         mismatches     = 0;
         expected_keying.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               mke_pkg::CSR_DASH:        dash_len    = csr_data[mke_pkg::DashWidth-1:0];
               mke_pkg::CSR_LETTER_GAP:  letter_gap  = csr_data;
               mke_pkg::CSR_WORD_GAP:    word_gap    = csr_data;
               mke_pkg::CSR_MESSAGE_GAP: message_gap = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predict_keying(req_symbol, req_message_end);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_keying.size() == 0) begin
               report_mismatch($sformatf(
                  "beat %0d with nothing expected: key_on %0b units %0d last %0b",
                  beat_count, rsp_key_on, rsp_units, rsp_last));
            end else begin
               want = expected_keying.pop_front();
               if (rsp_key_on !== want.key_on) begin
                  report_mismatch($sformatf("beat %0d key_on %0b, want %0b",
                                            beat_count, rsp_key_on, want.key_on));
               end
               if (rsp_units !== want.units) begin
                  report_mismatch($sformatf("beat %0d units %0d, want %0d",
                                            beat_count, rsp_units, want.units));
               end
               if (rsp_last !== want.last) begin
                  report_mismatch($sformatf("beat %0d last %0b, want %0b",
                                            beat_count, rsp_last, want.last));
               end
            end
            beat_count++;
         end
      end
      outstanding <= expected_keying.size();
   end

endmodule

[verif/tb_morse_keying_encoder.sv]
// Testbench top for morse_keying_encoder: clock, reset, character stimulus,
// register settings and rsp stall; checking is left to mke_checker.
// Depends on mke_pkg, morse_keying_encoder and mke_checker.

module tb_morse_keying_encoder;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [mke_pkg::SymbolWidth-1:0]    req_symbol = '0;
   logic                               req_message_end = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic                               rsp_key_on;
   logic [mke_pkg::UnitsWidth-1:0]     rsp_units;
   logic                               rsp_last;
   logic                               csr_write = 1'b0;
   logic [mke_pkg::CsrIdxWidth-1:0]    csr_index = '0;
   logic [mke_pkg::UnitsWidth-1:0]     csr_data = '0;

   int mismatches;
   int outstanding;
   int sender_idle_pct = 0;
   int stall_pct = 0;

   always #5 clock = ~clock;

   morse_keying_encoder DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_symbol      (req_symbol),
      .req_message_end (req_message_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_on      (rsp_key_on),
      .rsp_units       (rsp_units),
      .rsp_last        (rsp_last),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   mke_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_symbol      (req_symbol),
      .req_message_end (req_message_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_on      (rsp_key_on),
      .rsp_units       (rsp_units),
      .rsp_last        (rsp_last),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // Returns at the edge that took the character; valid is still high then.
   task automatic send_symbol(input logic [7:0] sym, input logic fin);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_symbol      <= sym;
      req_message_end <= fin;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and hold off until every predicted beat is back.
   task automatic drain_keying();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_timing(input logic [5:0] dash, input logic [5:0] lgap,
                               input logic [5:0] wgap, input logic [5:0] mgap);
      csr_write <= 1'b1;
      csr_index <= mke_pkg::CSR_DASH;
      csr_data  <= dash;
      @(posedge clock);
      csr_index <= mke_pkg::CSR_LETTER_GAP;
      csr_data  <= lgap;
      @(posedge clock);
      csr_index <= mke_pkg::CSR_WORD_GAP;
      csr_data  <= wgap;
      @(posedge clock);
      csr_index <= mke_pkg::CSR_MESSAGE_GAP;
      csr_data  <= mgap;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Mostly text in either case with marks and spaces; the rest any byte.
   function automatic logic [7:0] pick_symbol();
      logic [7:0] marks[6];
      int         r;
      marks = '{8'h2E, 8'h2C, 8'h3F, 8'h3B, 8'h3A, 8'h21};
      r = $urandom_range(99);
      if (r < 55) begin
         return 8'h61 + 8'($urandom_range(25)) - ($urandom_range(1) ? 8'h20 : 8'h00);
      end else if (r < 65) begin
         return marks[$urandom_range(5)];
      end else if (r < 80) begin
         return mke_pkg::SpaceChar;
      end
      return 8'($urandom_range(255));
   endfunction

   initial begin
      logic [7:0] opening[21];
      logic       opening_end[21];
      opening     = '{8'h41, 8'h5A, 8'h61, 8'h7A, 8'h2E, 8'h2C, 8'h3F, 8'h3B, 8'h3A,
                      8'h21, 8'h20, 8'h20, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h40,
                      8'h5B, 8'h60, 8'h7B, 8'h53};
      // the byte after the first message end keys nothing at all
      opening_end = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                      1'b1};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults
      for (int i = 0; i < 21; i++) begin
         send_symbol(opening[i], opening_end[i]);
      end
      drain_keying();

      // every register at zero keys one unit
      write_timing(6'd0, 6'd0, 6'd0, 6'd0);
      send_symbol(8'h6F, 1'b0);
      send_symbol(8'h71, 1'b0);
      send_symbol(8'h20, 1'b1);
      send_symbol(8'h21, 1'b1);
      drain_keying();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               write_timing(6'h3F, 6'd63, 6'd63, 6'd63);
               sender_idle_pct = 0;
               stall_pct       = 0;
            end
            1: begin
               write_timing(6'($urandom_range(63)), 6'($urandom_range(63)),
                            6'($urandom_range(63)), 6'($urandom_range(63)));
               sender_idle_pct = 50;
               stall_pct       = 0;
            end
            2: begin
               write_timing(6'd1, 6'd1, 6'd1, 6'd1);
               sender_idle_pct = 0;
               stall_pct       = 50;
            end
            default: begin
               write_timing(6'($urandom_range(63)), 6'($urandom_range(63)),
                            6'($urandom_range(63)), 6'($urandom_range(63)));
               sender_idle_pct = 19;
               stall_pct       = 19;
            end
         endcase
         for (int n = 0; n < 75; n++) begin
            send_symbol(pick_symbol(), $urandom_range(11) == 0);
         end
         drain_keying();
      end

      stall_pct = 0;
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("tb: failure");
      $finish;
   end

endmodule
